@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the cosine similarity block.
// Plain text macros only; no other files are needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds in the same cycle in which the condition holds.
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("cosine similarity check failed");

// The property holds in the cycle after the one in which the condition holds.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("cosine similarity check failed");

`endif

@@ rtl/cs_pkg.sv @@
// Package of the cosine similarity block: widths, payload structs, the
// back end state type and the multiplier request and response structs.
// Depends on nothing.
`timescale 1ns / 1ps

package cs_pkg;

  localparam int ELEM_W  = 16;
  localparam int SCORE_W = 16;
  localparam int DOT_W   = 40;
  localparam int NORM_W  = 39;
  localparam int PROD_W  = 32;
  localparam int SQ_W    = 31;

  // Shared multiplier: 40 x 40 bits in four 20 x 20 partial products.
  localparam int MUL_W   = 40;
  localparam int HALF_W  = 20;
  localparam int MULP_W  = 80;

  // Square root search: norm product, x times norm product, remainder.
  localparam int P_W     = 78;
  localparam int B_W     = 94;
  localparam int ROOT_W  = 111;
  localparam int X_W     = 16;
  localparam int K_W     = 4;
  localparam int R_SHIFT = 30;

  localparam logic [SCORE_W-1:0] ONE_Q14 = 16'd16384;

  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [NORM_W-1:0]       NORM_MAX = {NORM_W{1'b1}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } sums_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MULP_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_ROOT_SUM,
    ST_ROOT_CMP,
    ST_FIN
  } back_state_t;

endpackage

@@ rtl/cs_front.sv @@
// Front end: multiplies each accepted element pair, accumulates the dot
// product and both sums of squares with saturation, and pushes the sums on
// the last pair. Depends on cs_pkg.
`timescale 1ns / 1ps

module cs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  cs_pkg::in_item_t in_item,
  output logic             last_pend,
  output logic             push,
  output cs_pkg::sums_t    push_data
);

  logic                              s1_valid_r;
  logic                              s1_last_r;
  logic signed [cs_pkg::PROD_W-1:0]  p_ab_r;
  logic [cs_pkg::SQ_W-1:0]           p_aa_r;
  logic [cs_pkg::SQ_W-1:0]           p_bb_r;

  logic signed [cs_pkg::PROD_W-1:0]  p_ab;
  logic signed [cs_pkg::PROD_W-1:0]  p_aa;
  logic signed [cs_pkg::PROD_W-1:0]  p_bb;

  logic signed [cs_pkg::DOT_W-1:0]   dot_r;
  logic [cs_pkg::NORM_W-1:0]         na_r;
  logic [cs_pkg::NORM_W-1:0]         nb_r;

  logic [cs_pkg::DOT_W:0]            dot_sum;
  logic [cs_pkg::NORM_W:0]           na_sum;
  logic [cs_pkg::NORM_W:0]           nb_sum;
  logic signed [cs_pkg::DOT_W-1:0]   dot_sat;
  logic [cs_pkg::NORM_W-1:0]         na_sat;
  logic [cs_pkg::NORM_W-1:0]         nb_sat;

  assign p_ab = in_item.elem_a * in_item.elem_b;
  assign p_aa = in_item.elem_a * in_item.elem_a;
  assign p_bb = in_item.elem_b * in_item.elem_b;

  // Squares are never negative and never above 2^30.
  always_ff @(posedge clk) begin
    p_ab_r <= p_ab;
    p_aa_r <= p_aa[cs_pkg::SQ_W-1:0];
    p_bb_r <= p_bb[cs_pkg::SQ_W-1:0];
    s1_last_r <= in_item.last_element;
  end

  always_comb begin
    dot_sum = {dot_r[cs_pkg::DOT_W-1], dot_r}
            + {{(cs_pkg::DOT_W+1-cs_pkg::PROD_W){p_ab_r[cs_pkg::PROD_W-1]}}, p_ab_r};
    na_sum  = {1'b0, na_r} + {{(cs_pkg::NORM_W+1-cs_pkg::SQ_W){1'b0}}, p_aa_r};
    nb_sum  = {1'b0, nb_r} + {{(cs_pkg::NORM_W+1-cs_pkg::SQ_W){1'b0}}, p_bb_r};

    if (dot_sum[cs_pkg::DOT_W] != dot_sum[cs_pkg::DOT_W-1]) begin
      dot_sat = dot_sum[cs_pkg::DOT_W] ? cs_pkg::DOT_MIN : cs_pkg::DOT_MAX;
    end else begin
      dot_sat = dot_sum[cs_pkg::DOT_W-1:0];
    end
    na_sat = na_sum[cs_pkg::NORM_W] ? cs_pkg::NORM_MAX : na_sum[cs_pkg::NORM_W-1:0];
    nb_sat = nb_sum[cs_pkg::NORM_W] ? cs_pkg::NORM_MAX : nb_sum[cs_pkg::NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      dot_r      <= '0;
      na_r       <= '0;
      nb_r       <= '0;
    end else begin
      s1_valid_r <= accept;
      if (s1_valid_r) begin
        if (s1_last_r) begin
          dot_r <= '0;
          na_r  <= '0;
          nb_r  <= '0;
        end else begin
          dot_r <= dot_sat;
          na_r  <= na_sat;
          nb_r  <= nb_sat;
        end
      end
    end
  end

  assign last_pend        = s1_valid_r & s1_last_r;
  assign push             = last_pend;
  assign push_data.dot    = dot_sat;
  assign push_data.norm_a = na_sat;
  assign push_data.norm_b = nb_sat;

endmodule

@@ rtl/cs_queue.sv @@
// Short queue of finished vector sums between the front and back ends.
// Depends on cs_pkg.
`timescale 1ns / 1ps

module cs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cs_pkg::sums_t                push_data,
  input  logic                         pop,
  output logic                         valid,
  output cs_pkg::sums_t                pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  cs_pkg::sums_t     mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign valid    = (count_r != '0);
  assign count    = count_r;

endmodule

@@ rtl/cs_mul.sv @@
// Shared 40 x 40 bit unsigned multiplier built from one 20 x 20 bit
// multiplier, one partial product per cycle. Depends on cs_pkg.
`timescale 1ns / 1ps

module cs_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  cs_pkg::mul_req_t req,
  output cs_pkg::mul_rsp_t rsp
);

  logic                        busy_r;
  logic [2:0]                  cnt_r;
  logic                        pp_v_r;
  logic                        done_r;
  logic [cs_pkg::MUL_W-1:0]    a_r, b_r;
  logic [2*cs_pkg::HALF_W-1:0] pp_r;
  logic [1:0]                  pp_sh_r;
  logic [cs_pkg::MULP_W-1:0]   acc_r;

  logic [cs_pkg::HALF_W-1:0]   sel_a, sel_b;
  logic [cs_pkg::MULP_W-1:0]   pp_ext;
  logic [cs_pkg::MULP_W-1:0]   pp_shifted;
  logic                        stepping;

  // Counter values 0 to 3 pick the halves; 4 means all issued.
  assign stepping = busy_r && !cnt_r[2];
  assign sel_a    = cnt_r[0] ? a_r[cs_pkg::MUL_W-1:cs_pkg::HALF_W] : a_r[cs_pkg::HALF_W-1:0];
  assign sel_b    = cnt_r[1] ? b_r[cs_pkg::MUL_W-1:cs_pkg::HALF_W] : b_r[cs_pkg::HALF_W-1:0];

  always_comb begin
    pp_ext = {{(cs_pkg::MULP_W-2*cs_pkg::HALF_W){1'b0}}, pp_r};
    case (pp_sh_r)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext << cs_pkg::HALF_W;
      2'd2:    pp_shifted = pp_ext << (2*cs_pkg::HALF_W);
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pp_v_r <= stepping;
      if (stepping) begin
        cnt_r <= cnt_r + 3'd1;
      end
      done_r <= busy_r && cnt_r[2] && pp_v_r;
      if (busy_r && cnt_r[2] && pp_v_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else begin
      pp_r    <= sel_a * sel_b;
      pp_sh_r <= 2'({1'b0, cnt_r[0]} + {1'b0, cnt_r[1]});
      if (pp_v_r) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

@@ rtl/cs_back.sv @@
// Back end: takes one set of sums from the queue; unless a norm is zero, forms
// the norm product and the scaled squared dot product on the shared multiplier,
// then finds the score one bit at a time. Depends on cs_pkg and cs_mul.
`timescale 1ns / 1ps

module cs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cs_pkg::sums_t     q_data,
  output logic              q_pop,
  output logic              out_valid,
  output cs_pkg::out_item_t out_item
);

  cs_pkg::back_state_t state_r, state_nxt;

  cs_pkg::mul_req_t mul_req;
  cs_pkg::mul_rsp_t mul_rsp;

  logic                       dot_neg_r;
  logic                       degen_r;
  logic [cs_pkg::MUL_W-1:0]   mag_r;
  logic [cs_pkg::P_W-1:0]     p_r;
  logic [cs_pkg::ROOT_W-1:0]  rem_r;
  logic [cs_pkg::ROOT_W-1:0]  sum_r;
  logic [cs_pkg::B_W-1:0]     bacc_r;
  logic [cs_pkg::X_W-1:0]     x_r;
  logic [cs_pkg::K_W-1:0]     k_r;
  logic                       out_valid_r, out_valid_nxt;
  cs_pkg::out_item_t          out_item_r;

  logic                       zero_norm;
  logic [cs_pkg::MUL_W-1:0]   dot_mag;
  logic [cs_pkg::ROOT_W:0]    diff;
  logic [cs_pkg::X_W:0]       x_plus1;
  logic [cs_pkg::SCORE_W-1:0] m_raw, m_clip;

  cs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign zero_norm = (q_data.norm_a == '0) || (q_data.norm_b == '0);
  assign dot_mag   = q_data.dot[cs_pkg::DOT_W-1] ? (~q_data.dot + 1'b1) : q_data.dot;
  assign diff      = {1'b0, rem_r} - {1'b0, sum_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cs_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = zero_norm ? cs_pkg::ST_FIN : cs_pkg::ST_MUL_P;
        end
      end
      cs_pkg::ST_MUL_P: begin
        if (mul_rsp.done) begin
          state_nxt = cs_pkg::ST_MUL_D;
        end
      end
      cs_pkg::ST_MUL_D: begin
        if (mul_rsp.done) begin
          state_nxt = cs_pkg::ST_ROOT_SUM;
        end
      end
      cs_pkg::ST_ROOT_SUM: state_nxt = cs_pkg::ST_ROOT_CMP;
      cs_pkg::ST_ROOT_CMP: begin
        state_nxt = (k_r == '0) ? cs_pkg::ST_FIN : cs_pkg::ST_ROOT_SUM;
      end
      cs_pkg::ST_FIN: state_nxt = cs_pkg::ST_IDLE;
      default: state_nxt = cs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = mag_r;
    mul_req.b     = mag_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      cs_pkg::ST_IDLE: begin
        q_pop         = q_valid;
        mul_req.start = q_valid && !zero_norm;
        mul_req.a     = {{(cs_pkg::MUL_W-cs_pkg::NORM_W){1'b0}}, q_data.norm_a};
        mul_req.b     = {{(cs_pkg::MUL_W-cs_pkg::NORM_W){1'b0}}, q_data.norm_b};
      end
      cs_pkg::ST_MUL_P: mul_req.start = mul_rsp.done;
      cs_pkg::ST_FIN:   out_valid_nxt = 1'b1;
      default: begin
      end
    endcase
  end

  // Search keeps rem = 2^30*dot^2 - x^2*P and bacc = x*P.
  always_ff @(posedge clk) begin
    case (state_r)
      cs_pkg::ST_IDLE: begin
        if (q_valid) begin
          mag_r     <= dot_mag;
          dot_neg_r <= q_data.dot[cs_pkg::DOT_W-1];
          degen_r   <= zero_norm;
        end
      end
      cs_pkg::ST_MUL_P: begin
        if (mul_rsp.done) begin
          p_r <= mul_rsp.prod[cs_pkg::P_W-1:0];
        end
      end
      cs_pkg::ST_MUL_D: begin
        if (mul_rsp.done) begin
          rem_r  <= cs_pkg::ROOT_W'({mul_rsp.prod, {cs_pkg::R_SHIFT{1'b0}}});
          bacc_r <= '0;
          x_r    <= '0;
          k_r    <= cs_pkg::K_W'(cs_pkg::X_W-1);
        end
      end
      cs_pkg::ST_ROOT_SUM: begin
        sum_r <= (cs_pkg::ROOT_W'(bacc_r) << ({1'b0, k_r} + 5'd1))
               + (cs_pkg::ROOT_W'(p_r) << {k_r, 1'b0});
      end
      cs_pkg::ST_ROOT_CMP: begin
        if (!diff[cs_pkg::ROOT_W]) begin
          rem_r    <= diff[cs_pkg::ROOT_W-1:0];
          bacc_r   <= bacc_r + (cs_pkg::B_W'(p_r) << k_r);
          x_r[k_r] <= 1'b1;
        end
        k_r <= k_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Largest odd value not above x gives m = floor((x+1)/2), clamped to one.
  always_comb begin
    x_plus1 = {1'b0, x_r} + 1'b1;
    m_raw   = x_plus1[cs_pkg::X_W:1];
    m_clip  = (m_raw > cs_pkg::ONE_Q14) ? cs_pkg::ONE_Q14 : m_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cs_pkg::ST_FIN) begin
      out_item_r.degenerate <= degen_r;
      if (degen_r) begin
        out_item_r.score <= '0;
      end else begin
        out_item_r.score <= dot_neg_r ? -m_clip : m_clip;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/cosine_similarity_top.sv @@
// Top level of the cosine similarity block: front end, sums queue and back
// end. Depends on cs_pkg, cs_front, cs_queue, cs_back and assert_macros.svh.
//
// Use: drive one element pair of the two vectors on in_item and raise start.
// The request is taken at a rising edge with start high and busy low. Mark
// the final pair of the vectors with last_element; that request closes the
// vectors, and one result then appears on out_item for exactly one cycle
// with out_valid high. Requests without the mark give no result.
// Throughput is one element pair per cycle while busy is low. With nonzero
// norms, the sums of the marked request pass the front end and the queue,
// then the back end forms two 40 x 40 bit products on the shared four-step
// multiplier, runs a 16-bit root search with a sum step and a compare step
// per bit and registers the result. A zero norm vector skips the products
// and the search and reports degenerate with score 0. The back end takes
// new sums only when idle; up to QUEUE_DEPTH closed vectors wait in the
// queue, so busy rises only when closed vectors arrive faster than the
// back end finishes them.
// Reset clears the sums, the queue and the back end sequencer. The receiver
// cannot stall; each result must be taken in the cycle it is shown.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosine_similarity_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cs_pkg::in_item_t  in_item,
  output logic              out_valid,
  output cs_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic             accept;
  logic             last_pend;
  logic             push;
  cs_pkg::sums_t    push_data;
  logic             q_valid;
  logic             q_pop;
  cs_pkg::sums_t    q_data;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W:0]   reserved;
  logic             score_in_range;

  // A request is taken only when the queue has room for every vector
  // already closed, including one whose last pair is still in the front end.
  assign accept   = start && !busy;
  assign reserved = {1'b0, q_count} + (CNT_W+1)'(last_pend);
  assign busy     = (reserved >= (CNT_W+1)'(QUEUE_DEPTH));

  cs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .last_pend (last_pend),
    .push      (push),
    .push_data (push_data)
  );

  cs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  cs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign score_in_range = (out_item.score <= 16'sd16384) && (out_item.score >= -16'sd16384);

  // The back end never shows two results in adjacent cycles.
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // A closed vector always finds room in the queue.
  `ASSERT_IMPLY(a_push_room, clk, rst_n, push, q_count < CNT_W'(QUEUE_DEPTH))
  // A degenerate result carries a zero score.
  `ASSERT_IMPLY(a_degen_zero, clk, rst_n, out_valid && out_item.degenerate, out_item.score == '0)
  // The score stays within plus or minus one in Q1.14.
  `ASSERT_IMPLY(a_score_range, clk, rst_n, out_valid, score_in_range)

endmodule
